FILE: sv/b64d_pkg.sv
`default_nettype none
package b64d_pkg;

    // queue between the decode front and the byte serializer
    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);

    // character codes
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_Z = 8'h5a;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_LOWER_Z = 8'h7a;
    localparam logic [7:0] CH_DIGIT_0 = 8'h30;
    localparam logic [7:0] CH_DIGIT_9 = 8'h39;
    localparam logic [7:0] CH_PLUS    = 8'h2b;
    localparam logic [7:0] CH_SLASH   = 8'h2f;

    // offsets that map each alphabet range onto its sextet value
    localparam logic [7:0] OFS_UPPER = 8'h41;
    localparam logic [7:0] OFS_LOWER = 8'h47;
    localparam logic [7:0] OFS_DIGIT = 8'hfc;
    localparam logic [5:0] SX_PLUS   = 6'd62;
    localparam logic [5:0] SX_SLASH  = 6'd63;

    // held sextet counts
    localparam logic [1:0] HELD_TWO   = 2'd2;
    localparam logic [1:0] HELD_THREE = 2'd3;

    // one decoded item: up to three results in emission order
    typedef struct packed {
        logic [7:0] b0;
        logic [7:0] b1;
        logic [7:0] b2;
        logic [1:0] nres;     // number of results, 1..3 (0 = none)
        logic       empty;    // single empty end marker
        logic       msg_end;  // last result closes the message
    } job_t;

    // bytes flushed out of a partial group
    typedef struct packed {
        logic [7:0] b0;
        logic [7:0] b1;
        logic [1:0] n;
    } flush_t;

    // sextet value in bits 5:0, bit 6 set for anything outside the alphabet
    function automatic logic [6:0] sextet_of(input logic [7:0] c);
        logic [7:0] d;
        logic [6:0] r;
        d = 8'd0;
        r = 7'h40;
        if (c inside {[CH_UPPER_A:CH_UPPER_Z]}) begin
            d = c - OFS_UPPER;
            r = {1'b0, d[5:0]};
        end else if (c inside {[CH_LOWER_A:CH_LOWER_Z]}) begin
            d = c - OFS_LOWER;
            r = {1'b0, d[5:0]};
        end else if (c inside {[CH_DIGIT_0:CH_DIGIT_9]}) begin
            d = c - OFS_DIGIT;
            r = {1'b0, d[5:0]};
        end else if (c == CH_PLUS) begin
            r = {1'b0, SX_PLUS};
        end else if (c == CH_SLASH) begin
            r = {1'b0, SX_SLASH};
        end
        return r;
    endfunction

    // held_count-1 bytes out of a partial group
    function automatic flush_t flush_group(input logic [17:0] st, input logic [1:0] cnt);
        flush_t f;
        f = '0;
        case (cnt)
            HELD_TWO:
            begin
                f.b0 = st[11:4];
                f.n  = 2'd1;
            end
            HELD_THREE:
            begin
                f.b0 = st[17:10];
                f.b1 = st[9:2];
                f.n  = 2'd2;
            end
            default:
            begin
                f = '0;
            end
        endcase
        return f;
    endfunction

endpackage
`default_nettype wire

FILE: sv/b64d_if.sv
`default_nettype none
// character channel
interface b64d_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_char;
    logic       last_char;

    modport source (output valid, output in_char, output last_char, input ready);
    modport sink   (input valid, input in_char, input last_char, output ready);
endinterface

// decoded byte channel
interface b64d_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       run_last;
    logic       message_end;

    modport source (output valid, output out_byte, output byte_valid,
                    output run_last, output message_end, input ready);
    modport sink   (input valid, input out_byte, input byte_valid,
                    input run_last, input message_end, output ready);
endinterface
`default_nettype wire

FILE: sv/b64d_front.sv
`default_nettype none
module b64d_front (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    input  wire logic [7:0]    in_char,
    input  wire logic          last_char,
    output logic               in_ready,
    input  wire logic          q_full,
    output logic               push,
    output b64d_pkg::job_t     push_job
);

    logic [17:0] store_reg, store_next;
    logic [1:0]  cnt_reg, cnt_next;
    logic        halted_reg, halted_next;
    logic        accept;

    assign in_ready = !q_full;
    assign accept   = in_valid && !q_full;

    // classify the character and build the job for this word
    always_comb
    begin
        logic [6:0]        sx;
        logic [23:0]       cat;
        logic [1:0]        c2;
        b64d_pkg::flush_t  f;
        sx          = b64d_pkg::sextet_of(in_char);
        cat         = {store_reg, sx[5:0]};
        c2          = cnt_reg + 2'd1;
        f           = '0;
        store_next  = store_reg;
        cnt_next    = cnt_reg;
        halted_next = halted_reg;
        push_job    = '0;
        if (!halted_reg) begin
            if (!sx[6]) begin
                if (cnt_reg == b64d_pkg::HELD_THREE) begin
                    // full group of four
                    push_job.b0   = cat[23:16];
                    push_job.b1   = cat[15:8];
                    push_job.b2   = cat[7:0];
                    push_job.nres = 2'd3;
                    store_next    = '0;
                    cnt_next      = '0;
                end else begin
                    store_next = cat[17:0];
                    cnt_next   = c2;
                    if (last_char) begin
                        f = b64d_pkg::flush_group(cat[17:0], c2);
                        push_job.b0   = f.b0;
                        push_job.b1   = f.b1;
                        push_job.nres = f.n;
                    end
                end
            end else begin
                // padding or invalid character halts the message
                halted_next   = 1'b1;
                f             = b64d_pkg::flush_group(store_reg, cnt_reg);
                push_job.b0   = f.b0;
                push_job.b1   = f.b1;
                push_job.nres = f.n;
                store_next    = '0;
                cnt_next      = '0;
            end
        end
        // end of message resets everything
        if (last_char) begin
            if (push_job.nres == 2'd0) begin
                push_job.nres  = 2'd1;
                push_job.empty = 1'b1;
            end
            push_job.msg_end = 1'b1;
            store_next       = '0;
            cnt_next         = '0;
            halted_next      = 1'b0;
        end
    end

    assign push = accept && (push_job.nres != 2'd0);

    // group state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            store_reg  <= '0;
            cnt_reg    <= '0;
            halted_reg <= 1'b0;
        end else if (accept) begin
            store_reg  <= store_next;
            cnt_reg    <= cnt_next;
            halted_reg <= halted_next;
        end
    end

endmodule
`default_nettype wire

FILE: sv/b64d_queue.sv
`default_nettype none
module b64d_queue (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  wire b64d_pkg::job_t push_job,
    output logic               full,
    input  wire logic          pop,
    output logic               head_valid,
    output b64d_pkg::job_t     head_job
);

    b64d_pkg::job_t                mem [b64d_pkg::QDEPTH];
    logic [b64d_pkg::QAW-1:0]      wr_reg, wr_next;
    logic [b64d_pkg::QAW-1:0]      rd_reg, rd_next;
    logic [b64d_pkg::QAW:0]        fill_reg, fill_next;
    logic                          do_push, do_pop;

    assign full       = (fill_reg == (b64d_pkg::QAW+1)'(b64d_pkg::QDEPTH));
    assign head_valid = (fill_reg != '0);
    assign head_job   = mem[rd_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    // pointer and fill update
    always_comb
    begin
        wr_next   = do_push ? wr_reg + 1'b1 : wr_reg;
        rd_next   = do_pop ? rd_reg + 1'b1 : rd_reg;
        fill_next = fill_reg;
        if (do_push && !do_pop) begin
            fill_next = fill_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_reg   <= '0;
            rd_reg   <= '0;
            fill_reg <= '0;
        end else begin
            wr_reg   <= wr_next;
            rd_reg   <= rd_next;
            fill_reg <= fill_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (do_push) begin
            mem[wr_reg] <= push_job;
        end
    end

endmodule
`default_nettype wire

FILE: sv/b64d_back.sv
`default_nettype none
module b64d_back (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           head_valid,
    input  wire b64d_pkg::job_t head_job,
    output logic                pop,
    output logic                out_valid,
    input  wire logic           out_ready,
    output logic [7:0]          out_byte,
    output logic                byte_valid,
    output logic                run_last,
    output logic                message_end
);

    logic [1:0] idx_reg, idx_next;
    logic       fire;

    assign out_valid = head_valid;
    assign fire      = head_valid && out_ready;
    assign run_last  = (idx_reg == head_job.nres - 2'd1);
    assign message_end = run_last && head_job.msg_end;
    assign byte_valid  = !head_job.empty;
    assign pop         = fire && run_last;

    // pick the byte for the current slot
    always_comb
    begin
        case (idx_reg)
            2'd0:    out_byte = head_job.b0;
            2'd1:    out_byte = head_job.b1;
            2'd2:    out_byte = head_job.b2;
            default: out_byte = 8'd0;
        endcase
        if (head_job.empty) begin
            out_byte = 8'd0;
        end
    end

    // slot counter within the current job
    always_comb
    begin
        idx_next = idx_reg;
        if (fire) begin
            idx_next = run_last ? 2'd0 : idx_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            idx_reg <= '0;
        end else begin
            idx_reg <= idx_next;
        end
    end

endmodule
`default_nettype wire

FILE: sv/base64_stream_decoder_core.sv
// a character is decoded in the cycle it is accepted; its job is registered in the
//   job queue and offered from there, one result word per ready cycle
// throughput: one character per cycle while the four-entry job queue has room;
//   the serializer drains one result word per ready cycle (three per full group)
// reset: rst_n clears the held group, halt flag, queue pointers and slot counter
`default_nettype none
module base64_stream_decoder_core (
    input  wire logic   clk,
    input  wire logic   rst_n,
    b64d_char_if.sink   text,
    b64d_byte_if.source data
);

    logic           q_full;
    logic           push;
    b64d_pkg::job_t push_job;
    logic           pop;
    logic           head_valid;
    b64d_pkg::job_t head_job;

    // decode front
    b64d_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (text.valid),
        .in_char   (text.in_char),
        .last_char (text.last_char),
        .in_ready  (text.ready),
        .q_full    (q_full),
        .push      (push),
        .push_job  (push_job)
    );

    // job queue
    b64d_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_job   (push_job),
        .full       (q_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_job   (head_job)
    );

    // byte serializer
    b64d_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head_valid  (head_valid),
        .head_job    (head_job),
        .pop         (pop),
        .out_valid   (data.valid),
        .out_ready   (data.ready),
        .out_byte    (data.out_byte),
        .byte_valid  (data.byte_valid),
        .run_last    (data.run_last),
        .message_end (data.message_end)
    );

endmodule
`default_nettype wire

FILE: tb/tb_base64_stream_decoder_core.sv
module tb_base64_stream_decoder_core;
    timeunit 1ns;
    timeprecision 1ps;

    // one character word on the input channel
    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } char_item_t;

    // one decoded word on the output channel
    typedef struct packed {
        logic [7:0] value;
        logic       valid;
        logic       run_last;
        logic       msg_end;
    } byte_word_t;

    logic clk;
    logic rst_n = 1'b0;

    // driven copies of the block inputs, known from time zero
    logic       drv_valid = 1'b0;
    logic [7:0] drv_char  = 8'h00;
    logic       drv_last  = 1'b0;
    logic       rcv_ready = 1'b0;

    b64d_char_if text_if ();
    b64d_byte_if data_if ();

    assign text_if.valid     = drv_valid;
    assign text_if.in_char   = drv_char;
    assign text_if.last_char = drv_last;
    assign data_if.ready     = rcv_ready;

    base64_stream_decoder_core DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .text  (text_if),
        .data  (data_if)
    );

    // decoder state mirror
    logic [17:0] held_sextets = '0;
    logic [1:0]  held_n       = '0;
    logic        halted       = 1'b0;

    char_item_t char_queue[$];
    byte_word_t expected_words[$];
    byte_word_t item_words[$];
    char_item_t on_bus;

    int idle_max     = 0;
    int stall_max    = 0;
    logic hold_on    = 1'b0;
    int idle_left    = 0;
    int stall_left   = 0;
    int error_count  = 0;
    int chars_taken  = 0;
    int words_seen   = 0;
    int messages_seen = 0;
    int live_chars   = 0;

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // watchdog
    initial
    begin
        #2ms;
        $display("TB_ERROR");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        error_count++;
        $display("mismatch @%0t: %s", $realtime, msg);
    endtask

    // 0..63 for an alphabet character, bit 6 set for anything else
    function automatic logic [6:0] alphabet_index(input logic [7:0] c);
        logic [7:0] d;
        if (c >= b64d_pkg::CH_UPPER_A && c <= b64d_pkg::CH_UPPER_Z)
        begin
            d = c - b64d_pkg::CH_UPPER_A;
            return {1'b0, d[5:0]};
        end
        if (c >= b64d_pkg::CH_LOWER_A && c <= b64d_pkg::CH_LOWER_Z)
        begin
            d = c - b64d_pkg::CH_LOWER_A + 8'd26;
            return {1'b0, d[5:0]};
        end
        if (c >= b64d_pkg::CH_DIGIT_0 && c <= b64d_pkg::CH_DIGIT_9)
        begin
            d = c - b64d_pkg::CH_DIGIT_0 + 8'd52;
            return {1'b0, d[5:0]};
        end
        if (c == b64d_pkg::CH_PLUS)
            return 7'd62;
        if (c == b64d_pkg::CH_SLASH)
            return 7'd63;
        return 7'h40;
    endfunction

    // character for a sextet value
    function automatic logic [7:0] alphabet_char(input logic [5:0] v);
        if (v < 6'd26)
            return b64d_pkg::CH_UPPER_A + 8'(v);
        if (v < 6'd52)
            return b64d_pkg::CH_LOWER_A + 8'(v - 6'd26);
        if (v < 6'd62)
            return b64d_pkg::CH_DIGIT_0 + 8'(v - 6'd52);
        if (v == 6'd62)
            return b64d_pkg::CH_PLUS;
        return b64d_pkg::CH_SLASH;
    endfunction

    function automatic byte_word_t data_word(input logic [7:0] b);
        byte_word_t w;
        w = '0;
        w.value = b;
        w.valid = 1'b1;
        return w;
    endfunction

    // partial group leaves as one byte fewer than the sextets held
    task automatic flush_held();
        if (held_n == 2'd2)
            item_words = {item_words, data_word(held_sextets[11:4])};
        else if (held_n == 2'd3)
        begin
            item_words = {item_words, data_word(held_sextets[17:10])};
            item_words = {item_words, data_word(held_sextets[9:2])};
        end
        held_sextets = '0;
        held_n = '0;
    endtask

    // expected words for one accepted character
    task automatic decode_char(input char_item_t it);
        logic [6:0]  sx;
        logic [23:0] grp;
        byte_word_t  end_w;
        item_words.delete();
        end_w = '0;
        if (!halted)
        begin
            sx = alphabet_index(it.ch);
            if (!sx[6])
            begin
                if (held_n == 2'd3)
                begin
                    grp = {held_sextets, sx[5:0]};
                    item_words = {item_words, data_word(grp[23:16])};
                    item_words = {item_words, data_word(grp[15:8])};
                    item_words = {item_words, data_word(grp[7:0])};
                    held_sextets = '0;
                    held_n = '0;
                end
                else
                begin
                    held_sextets = {held_sextets[11:0], sx[5:0]};
                    held_n = held_n + 2'd1;
                end
                if (it.last)
                    flush_held();
            end
            else
            begin
                // padding or junk stops the message
                halted = 1'b1;
                flush_held();
            end
        end
        if (it.last)
        begin
            if (item_words.size() == 0)
                item_words = {item_words, end_w};
            item_words[item_words.size()-1].msg_end = 1'b1;
            held_sextets = '0;
            held_n = '0;
            halted = 1'b0;
        end
        if (item_words.size() > 0)
            item_words[item_words.size()-1].run_last = 1'b1;
        expected_words = {expected_words, item_words};
    endtask

    // character driver
    always @(posedge clk or negedge rst_n)
    begin : char_driver
        int wait_n;
        if (!rst_n)
        begin
            drv_valid <= 1'b0;
            drv_char  <= 8'h00;
            drv_last  <= 1'b0;
            idle_left <= 0;
        end
        else
        begin
            wait_n = idle_left;
            if (drv_valid && text_if.ready)
            begin
                decode_char(on_bus);
                chars_taken++;
            end
            if (!drv_valid || text_if.ready)
            begin
                if (wait_n > 0)
                begin
                    wait_n--;
                    drv_valid <= 1'b0;
                end
                else if (char_queue.size() > 0)
                begin
                    on_bus = char_queue.pop_front();
                    drv_char  <= on_bus.ch;
                    drv_last  <= on_bus.last;
                    drv_valid <= 1'b1;
                    wait_n = $urandom_range(idle_max);
                end
                else
                    drv_valid <= 1'b0;
            end
            idle_left <= wait_n;
        end
    end

    // byte monitor and receiver stalls
    always @(posedge clk or negedge rst_n)
    begin : byte_monitor
        int s;
        byte_word_t exp_w;
        byte_word_t got;
        if (!rst_n)
        begin
            rcv_ready  <= 1'b0;
            stall_left <= 0;
        end
        else
        begin
            s = stall_left;
            if (data_if.valid && rcv_ready)
            begin
                got = {data_if.out_byte, data_if.byte_valid, data_if.run_last,
                       data_if.message_end};
                if (expected_words.size() == 0)
                    report_mismatch($sformatf("unexpected word %h", got));
                else
                begin
                    exp_w = expected_words.pop_front();
                    if (got.value !== exp_w.value)
                        report_mismatch($sformatf("out_byte %h, want %h",
                                                  got.value, exp_w.value));
                    if (got.valid !== exp_w.valid)
                        report_mismatch($sformatf("byte_valid %b, want %b",
                                                  got.valid, exp_w.valid));
                    if (got.run_last !== exp_w.run_last)
                        report_mismatch($sformatf("run_last %b, want %b",
                                                  got.run_last, exp_w.run_last));
                    if (got.msg_end !== exp_w.msg_end)
                        report_mismatch($sformatf("message_end %b, want %b",
                                                  got.msg_end, exp_w.msg_end));
                end
                words_seen++;
                if (got.msg_end === 1'b1)
                    messages_seen++;
                s = $urandom_range(stall_max);
            end
            if (hold_on)
                rcv_ready <= 1'b0;
            else if (s > 0)
            begin
                s--;
                rcv_ready <= 1'b0;
            end
            else
                rcv_ready <= 1'b1;
            stall_left <= s;
        end
    end

    // stimulus helpers
    task automatic push_char(input logic [7:0] ch, input logic last);
        char_item_t it;
        it.ch   = ch;
        it.last = last;
        char_queue = {char_queue, it};
    endtask

    task automatic queue_text(input string s);
        for (int i = 0; i < s.len(); i++)
            push_char(s[i], i == s.len() - 1);
    endtask

    // mostly well-formed messages, some broken ones, some pure noise
    task automatic queue_random_message();
        logic [7:0] msg[$];
        int kind;
        int groups;
        int tail;
        int pos;
        logic live;
        logic [6:0] sx;
        kind = $urandom_range(9);
        groups = ($urandom_range(3) == 0) ? $urandom_range(6) : $urandom_range(2);
        tail = $urandom_range(3);
        if (kind < 8)
        begin
            repeat (groups * 4 + tail)
                msg = {msg, alphabet_char(6'($urandom_range(63)))};
            if (kind < 6)
            begin
                // padded ending now and then
                if (tail >= 2 && $urandom_range(1))
                    repeat (4 - tail)
                        msg = {msg, 8'h3d};
            end
            else
            begin
                // junk somewhere inside, maybe more after it
                pos = $urandom_range(msg.size());
                msg.insert(pos, 8'($urandom_range(255)));
                repeat ($urandom_range(2))
                    msg = {msg, 8'($urandom_range(255))};
            end
        end
        else
        begin
            repeat ($urandom_range(6, 1))
                msg = {msg, 8'($urandom_range(255))};
        end
        if (msg.size() == 0)
            msg = {msg, alphabet_char(6'($urandom_range(63)))};
        live = 1'b1;
        foreach (msg[i])
        begin
            if (live || i == msg.size() - 1)
                live_chars++;
            sx = alphabet_index(msg[i]);
            if (sx[6])
                live = 1'b0;
            push_char(msg[i], i == msg.size() - 1);
        end
    endtask

    task automatic drain_queue();
        while (char_queue.size() != 0)
            @(posedge clk);
    endtask

    // reset, stimulus and end of run
    initial
    begin : stimulus
        int idle_set[5];
        int stall_set[5];
        idle_set  = '{0, 18, 0, 18, 6};
        stall_set = '{0, 0, 18, 18, 3};
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // directed: full group, padding, flushes, extremes, junk, whitespace
        queue_text("TWFu");
        queue_text("TQ==");
        queue_text("Za0=");
        queue_text("A");
        queue_text("//+9");
        push_char(8'h00, 1'b1);
        push_char("z", 1'b0);
        push_char("z", 1'b0);
        push_char(8'hff, 1'b0);
        push_char("Q", 1'b1);
        queue_text("a9 ");
        drain_queue();

        // random phases with different idle mixes
        for (int ph = 0; ph < 5; ph++)
        begin
            idle_max  = idle_set[ph];
            stall_max = stall_set[ph];
            live_chars = 0;
            while (live_chars < 10)
                queue_random_message();
            if (ph == 0)
            begin
                // six full groups, more jobs than the queue holds
                queue_text("TWFuTWFuTWFuTWFuTWFuTWFu");
                // long receiver hold so the job queue fills and text stalls
                @(posedge clk);
                hold_on <= 1'b1;
                repeat (300) @(posedge clk);
                hold_on <= 1'b0;
            end
            drain_queue();
        end

        while (char_queue.size() != 0 || drv_valid)
            @(posedge clk);
        while (expected_words.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        $display("decoded %0d characters over %0d messages, %0d byte words checked",
                 chars_taken, messages_seen, words_seen);
        $display("covered padding, junk halts, partial flushes and long output stalls");
        if (error_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

FILE: files.f
sv/b64d_pkg.sv
sv/b64d_if.sv
sv/b64d_front.sv
sv/b64d_queue.sv
sv/b64d_back.sv
sv/base64_stream_decoder_core.sv
tb/tb_base64_stream_decoder_core.sv
